[rtl/itaf_pkg.sv]
package itaf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;

    // Digit counts derived from the value width (log10(2) ~ 0.302)
    localparam int DEC_DIGITS = (VALUE_WIDTH * 302) / 1000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);

    localparam logic [1:0] ACTION_UNSIGNED = 2'd0;
    localparam logic [1:0] ACTION_SIGNED   = 2'd1;
    localparam int         ACTION_HEX_BIT  = 1;

    localparam logic [1:0] PFX_NONE  = 2'd0;
    localparam logic [1:0] PFX_MINUS = 2'd1;
    localparam logic [1:0] PFX_HEX   = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_X     = 8'h78;

    typedef struct packed {
        logic [DIG_W-1:0] digits;   // left aligned, most significant nibble first
        logic [CNT_W-1:0] ndig;     // nibbles in use
        logic [1:0]       prefix;
    } emit_load_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            c = CHAR_UPPER + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

[rtl/itaf_bcd_unit.sv]
// Iterative double dabble: one bit per cycle.
module itaf_bcd_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [itaf_pkg::VALUE_WIDTH-1:0]    bin,
    output logic                                done,
    output logic [itaf_pkg::DIG_W-1:0]          bcd
);

    logic [itaf_pkg::VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [itaf_pkg::DIG_W-1:0]       bcd_reg, bcd_next;
    logic [itaf_pkg::BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                             run_reg, run_next;
    logic                             done_reg, done_next;
    logic [itaf_pkg::DIG_W-1:0]       adj;

    // add 3 to every nibble of 5 or more
    always_comb
    begin
        for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = bin;
            bcd_next = '0;
            cnt_next = itaf_pkg::BIT_CNT_W'(itaf_pkg::VALUE_WIDTH);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[itaf_pkg::DIG_W-2:0], bin_reg[itaf_pkg::VALUE_WIDTH-1]};
            bin_next = bin_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == itaf_pkg::BIT_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

[rtl/itaf_emitter.sv]
// Leading-zero trim by nibble shift, then prefix and digit characters.
module itaf_emitter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  itaf_pkg::emit_load_t  cmd,
    output logic                  done,
    output logic                  strobe,
    output logic [7:0]            character,
    output logic                  last
);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_TRIM = 3'd1;
    localparam logic [2:0] E_PFX0 = 3'd2;
    localparam logic [2:0] E_PFX1 = 3'd3;
    localparam logic [2:0] E_DIG  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [itaf_pkg::DIG_W-1:0]  dig_reg, dig_next;
    logic [itaf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]                  pfx_reg, pfx_next;
    logic                        strobe_reg, strobe_next;
    logic [7:0]                  char_reg, char_next;
    logic                        last_reg, last_next;
    logic [3:0]                  top_nib;
    logic                        one_left;

    assign top_nib  = dig_reg[itaf_pkg::DIG_W-1 -: 4];
    assign one_left = (cnt_reg == itaf_pkg::CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        cnt_next    = cnt_reg;
        pfx_next    = pfx_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        done        = 1'b0;
        case (state_reg)
            E_IDLE:
            begin
                if (load)
                begin
                    dig_next   = cmd.digits;
                    cnt_next   = cmd.ndig;
                    pfx_next   = cmd.prefix;
                    state_next = E_TRIM;
                end
            end
            E_TRIM:
            begin
                if (top_nib == 4'd0 && !one_left)
                begin
                    dig_next = dig_reg << 4;
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (pfx_reg == itaf_pkg::PFX_NONE)
                begin
                    state_next = E_DIG;
                end
                else
                begin
                    state_next = E_PFX0;
                end
            end
            E_PFX0:
            begin
                strobe_next = 1'b1;
                if (pfx_reg == itaf_pkg::PFX_HEX)
                begin
                    char_next  = itaf_pkg::CHAR_ZERO;
                    state_next = E_PFX1;
                end
                else
                begin
                    char_next  = itaf_pkg::CHAR_MINUS;
                    state_next = E_DIG;
                end
            end
            E_PFX1:
            begin
                strobe_next = 1'b1;
                char_next   = itaf_pkg::CHAR_X;
                state_next  = E_DIG;
            end
            E_DIG:
            begin
                strobe_next = 1'b1;
                char_next   = itaf_pkg::digit_char(top_nib);
                last_next   = one_left;
                dig_next    = dig_reg << 4;
                cnt_next    = cnt_reg - 1'b1;
                if (one_left)
                begin
                    done       = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        pfx_reg  <= pfx_next;
        char_reg <= char_next;
    end

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

[rtl/integer_to_ascii_formatter.sv]
// Integer to ASCII formatter. Pulse start with action and value while busy is low;
// the number's text then comes out one character per strobe, most significant
// first, with last high on the final character. The receiver cannot stall: each
// character is on character/last for exactly one cycle with strobe high, and must
// be taken then. Actions: 0 unsigned decimal, 1 signed decimal (leading '-'),
// 2 or 3 hex with "0x" prefix and uppercase digits; leading zeros are dropped.
// Decimal first runs the bit-serial BCD converter; hex skips it. The emitter then
// loads the digits, drops leading zeros one at a time, picks the prefix and puts
// out the characters. busy falls with the last strobe, so a new item can start
// in that cycle.
module integer_to_ascii_formatter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [itaf_pkg::IN_W-1:0]   value,
    output logic                        strobe,
    output logic [7:0]                  character,
    output logic                        last
);

    // top sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                         state_reg, state_next;
    logic                               neg_reg, neg_next;
    logic                               accept;
    logic                               is_hex;
    logic                               is_neg;
    logic [itaf_pkg::VALUE_WIDTH-1:0]   v_in;
    logic [itaf_pkg::VALUE_WIDTH-1:0]   mag;
    logic [itaf_pkg::DIG_W-1:0]         hex_digits;
    logic                               bcd_done;
    logic [itaf_pkg::DIG_W-1:0]         bcd;
    logic                               emit_load;
    logic                               emit_done;
    itaf_pkg::emit_load_t               emit_cmd;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign v_in   = itaf_pkg::VALUE_WIDTH'(value);
    assign is_hex = action[itaf_pkg::ACTION_HEX_BIT];
    assign is_neg = (action == itaf_pkg::ACTION_SIGNED) && v_in[itaf_pkg::VALUE_WIDTH-1];

    // Magnitude for signed decimal; the most negative value negates to itself,
    // which read unsigned is exactly 2^(VALUE_WIDTH-1).
    assign mag = is_neg ? (~v_in + 1'b1) : v_in;

    // Hex nibbles left aligned in the digit word
    assign hex_digits = itaf_pkg::DIG_W'(itaf_pkg::HEX_W'(v_in))
                        << (itaf_pkg::DIG_W - itaf_pkg::HEX_W);

    // Hex loads the emitter at accept; decimal loads when the converter is done
    assign emit_load = (accept && is_hex) || bcd_done;

    always_comb
    begin
        if (bcd_done)
        begin
            emit_cmd.digits = bcd;
            emit_cmd.ndig   = itaf_pkg::CNT_W'(itaf_pkg::DEC_DIGITS);
            emit_cmd.prefix = neg_reg ? itaf_pkg::PFX_MINUS : itaf_pkg::PFX_NONE;
        end
        else
        begin
            emit_cmd.digits = hex_digits;
            emit_cmd.ndig   = itaf_pkg::CNT_W'(itaf_pkg::HEX_DIGITS);
            emit_cmd.prefix = itaf_pkg::PFX_HEX;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = is_neg;
                    state_next = is_hex ? S_EMIT : S_CONV;
                end
            end
            S_CONV:
            begin
                if (bcd_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
        end
    end

    // bit-serial binary to BCD unit for both decimal actions
    itaf_bcd_unit u_bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && !is_hex),
        .bin   (mag),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    // character sequencer, drives the registered result ports
    itaf_emitter u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .cmd       (emit_cmd),
        .done      (emit_done),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for integer_to_ascii_formatter.
// Items go in through start/busy; characters come back one per strobe and
// cannot be held off. Each accepted item is expanded into its expected text
// right away, and every strobe is checked against the oldest character still
// pending.
module tb;

    // Action codes the package leaves unnamed: bit 1 picks hex, so 3 is hex too
    localparam logic [1:0] ACTION_HEX     = 2'd2;
    localparam logic [1:0] ACTION_HEX_ALT = 2'd3;

    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 60;
    localparam int DIR_ROWS     = 21;

    typedef struct {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [1:0]                    action;
    logic [itaf_pkg::IN_W-1:0]     value;
    logic                          strobe;
    logic [7:0]                    character;
    logic                          last;

    text_char_t pending_text[$];
    int         mismatches;

    integer_to_ascii_formatter i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .value     (value),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    // Directed rows. An empty text means: let the predictor work it out.
    logic [1:0]      dir_action [DIR_ROWS] = '{
        itaf_pkg::ACTION_UNSIGNED, itaf_pkg::ACTION_UNSIGNED, itaf_pkg::ACTION_UNSIGNED,
        itaf_pkg::ACTION_UNSIGNED, itaf_pkg::ACTION_UNSIGNED, itaf_pkg::ACTION_UNSIGNED,
        itaf_pkg::ACTION_UNSIGNED,
        itaf_pkg::ACTION_SIGNED,   itaf_pkg::ACTION_SIGNED,   itaf_pkg::ACTION_SIGNED,
        itaf_pkg::ACTION_SIGNED,   itaf_pkg::ACTION_SIGNED,   itaf_pkg::ACTION_SIGNED,
        itaf_pkg::ACTION_SIGNED,
        ACTION_HEX,      ACTION_HEX,      ACTION_HEX,      ACTION_HEX,
        ACTION_HEX,      ACTION_HEX_ALT,  ACTION_HEX_ALT
    };
    logic [itaf_pkg::IN_W-1:0] dir_value  [DIR_ROWS] = '{
        32'd0,           32'd1,           32'd9,           32'd10,
        32'd1000000000,  32'h8000_0000,   32'hFFFF_FFFF,
        32'd0,           32'hFFFF_FFFF,   32'h8000_0000,   32'h7FFF_FFFF,
        32'h8000_0001,   32'hFFFF_FFF6,   32'd123456,
        32'd0,           32'h0000_000A,   32'h1234_5678,   32'h8000_0000,
        32'hFFFF_FFFF,   32'd0,           32'hABCD_EF09
    };
    string           dir_text   [DIR_ROWS] = '{
        "0",             "",              "",              "",
        "",              "2147483648",    "4294967295",
        "0",             "-1",            "-2147483648",   "2147483647",
        "",              "-10",           "",
        "0x0",           "0xA",           "0x12345678",    "0x80000000",
        "0xFFFFFFFF",    "0x0",           "0xABCDEF09"
    };

    function automatic void push_char(input logic [7:0] c, input logic is_last);
        text_char_t t;
        t.character = c;
        t.last      = is_last;
        pending_text.push_back(t);
    endfunction

    // Predictor: expands one item into the characters it should produce.
    function automatic void format_text(input logic [1:0] act,
                                        input logic [itaf_pkg::IN_W-1:0] val);
        logic [7:0]  digits [24];
        int          nd;
        logic [63:0] mask;
        logic [63:0] v;
        logic [3:0]  d;
        mask = (64'd2 << (itaf_pkg::VALUE_WIDTH - 1)) - 64'd1;
        v    = 64'(val) & mask;
        nd   = 0;
        if (act[itaf_pkg::ACTION_HEX_BIT])
        begin
            push_char(itaf_pkg::CHAR_ZERO, 1'b0);
            push_char(itaf_pkg::CHAR_X, 1'b0);
            do
            begin
                d = v[3:0];
                digits[nd] = (d < 4'd10) ? itaf_pkg::CHAR_ZERO + 8'(d)
                                         : itaf_pkg::CHAR_UPPER + 8'(d) - 8'd10;
                nd = nd + 1;
                v = v >> 4;
            end
            while (v != 64'd0);
        end
        else
        begin
            // Signed: minus sign, then the magnitude (most negative value
            // wraps to itself, which is exactly 2^(W-1) read as unsigned)
            if (act == itaf_pkg::ACTION_SIGNED && v[itaf_pkg::VALUE_WIDTH-1])
            begin
                push_char(itaf_pkg::CHAR_MINUS, 1'b0);
                v = (~v + 64'd1) & mask;
            end
            do
            begin
                digits[nd] = itaf_pkg::CHAR_ZERO + 8'(v % 64'd10);
                nd = nd + 1;
                v = v / 64'd10;
            end
            while (v != 64'd0);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            push_char(digits[k], k == 0);
        end
    endfunction

    // Hand one item to the block, idling first when `gap` is nonzero. Returns on the edge
    // that accepted it, leaving start high so a back-to-back item can follow
    // with a single assignment.
    task automatic send_item(input logic [1:0] act, input logic [itaf_pkg::IN_W-1:0] val,
                             input string txt, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (txt.len() == 0)
        begin
            format_text(act, val);
        end
        else
        begin
            for (int k = 0; k < txt.len(); k++)
            begin
                push_char(txt[k], k == txt.len() - 1);
            end
        end
    endtask

    // Let everything in flight come out before going on
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Character checker: strobe is sampled at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_text.size() == 0)
            begin
                $error("unexpected character: got %h last %b", character, last);
                mismatches++;
            end
            else
            begin
                if (character !== pending_text[0].character)
                begin
                    $error("character: expected %h, got %h",
                           pending_text[0].character, character);
                    mismatches++;
                end
                if (last !== pending_text[0].last)
                begin
                    $error("last: expected %b, got %b", pending_text[0].last, last);
                    mismatches++;
                end
                void'(pending_text.pop_front());
            end
        end
    end

    // Watchdog: the slowest legal run is well under a millisecond
    initial
    begin
        #5_000_000;
        $display("** integer_to_ascii_formatter: FAILED **");
        $finish;
    end

    initial
    begin
        logic [1:0]                act;
        logic [itaf_pkg::IN_W-1:0] val;
        int                        gap;
        bit                        no_idle;
        mismatches = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = '0;
        value      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every action including the unused code
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_item(dir_action[r], dir_value[r], dir_text[r], $urandom_range(0, 6));
        end

        // Sender holds off until the block has gone quiet
        wait_drained();

        no_idle = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Every 40 items pick anew between back-to-back and random gaps
            if (i % 40 == 0)
            begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                wait_drained();
            end
            act = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: val = $urandom();                         // full range
                1: val = $urandom_range(0, 999);             // short texts
                2: val = $urandom_range(0, 15);              // single digit / hex edge
                3: val = 32'h8000_0000 + $urandom_range(0, 3) - 2;  // sign boundary
                4: val = ~32'($urandom_range(0, 1000));      // small negatives
                default:
                begin
                    // Near powers of ten and sixteen: digit count changes
                    val = 1;
                    repeat ($urandom_range(1, 9)) val = val * 10;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        val = 32'd1 << (4 * $urandom_range(1, 7));
                    end
                    val = val + $urandom_range(0, 2) - 1;
                end
            endcase
            gap = no_idle ? 0 : $urandom_range(0, 6);
            send_item(act, val, "", gap);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("** integer_to_ascii_formatter: PASSED **");
        end
        else
        begin
            $display("** integer_to_ascii_formatter: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/itaf_pkg.sv
rtl/itaf_bcd_unit.sv
rtl/itaf_emitter.sv
rtl/integer_to_ascii_formatter.sv
tb/tb.sv
